/* hw/rtl/ir_pulse_distance_decoder_macros.svh */
// Assertion macros for the infrared pulse distance decoder
// Used by files that hold concurrent checks; needs clk_i and rst_ni in scope
`ifndef IR_PULSE_DISTANCE_DECODER_MACROS_SVH
`define IR_PULSE_DISTANCE_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define IRPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define IRPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/irpd_pkg.sv */
// Shared types, constants and window compare for the pulse distance decoder
// No dependencies
`timescale 1ns / 1ps

package irpd_pkg;

  // sizes
  localparam int unsigned WIDTH_W   = 16;
  localparam int unsigned CODE_W    = 64;
  localparam int unsigned CODE_BITS = 64;
  localparam int unsigned IDX_W     = $clog2(CODE_W);
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned CFG_IDX_W = 3;

  // decode phases
  typedef enum logic [2:0] {
    PH_HDR_MARK,
    PH_HDR_SPACE,
    PH_BIT_MARK,
    PH_BIT_SPACE,
    PH_HALTED
  } phase_e;

  // frame status codes
  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_HEADER   = 2'd1,
    ST_BADSPACE = 2'd2,
    ST_EARLY    = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HDR_MARK   = 3'd0,
    CFG_HDR_SPACE  = 3'd1,
    CFG_BIT_MARK   = 3'd2,
    CFG_ZERO_SPACE = 3'd3,
    CFG_ONE_SPACE  = 3'd4,
    CFG_MARK_TOL   = 3'd5,
    CFG_SPACE_TOL  = 3'd6
  } cfg_idx_e;

  // configuration register file
  typedef struct packed {
    logic [WIDTH_W-1:0] hdr_mark;
    logic [WIDTH_W-1:0] hdr_space;
    logic [WIDTH_W-1:0] bit_mark;
    logic [WIDTH_W-1:0] zero_space;
    logic [WIDTH_W-1:0] one_space;
    logic [WIDTH_W-1:0] mark_tol;
    logic [WIDTH_W-1:0] space_tol;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    hdr_mark:   16'd6100,
    hdr_space:  16'd7600,
    bit_mark:   16'd550,
    zero_space: 16'd1500,
    one_space:  16'd3500,
    mark_tol:   16'd150,
    space_tol:  16'd200
  };

  // strict window: nominal - tol < w < nominal + tol, without wrap
  function automatic logic in_window(logic [WIDTH_W-1:0] w,
                                     logic [WIDTH_W-1:0] nom,
                                     logic [WIDTH_W-1:0] tol);
    logic [WIDTH_W:0] w_plus_tol;
    logic [WIDTH_W:0] nom_plus_tol;
    w_plus_tol   = {1'b0, w} + {1'b0, tol};
    nom_plus_tol = {1'b0, nom} + {1'b0, tol};
    return ({1'b0, nom} < w_plus_tol) && ({1'b0, w} < nom_plus_tol);
  endfunction

endpackage

/* hw/rtl/irpd_if.sv */
// Channel interfaces of the pulse distance decoder: pulses, results, configuration
// Depends on irpd_pkg
`timescale 1ns / 1ps

// pulse width items
interface irpd_in_if import irpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] pulse_width;
  logic               frame_end;

  modport source (output valid, pulse_width, frame_end, input ready);
  modport sink   (input valid, pulse_width, frame_end, output ready);
endinterface

// decoded frame items
interface irpd_out_if import irpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CODE_W-1:0] code_bits;
  logic [CNT_W-1:0]  bits_decoded;
  logic [1:0]        frame_status;

  modport source (output valid, code_bits, bits_decoded, frame_status, input ready);
  modport sink   (input valid, code_bits, bits_decoded, frame_status, output ready);
endinterface

// register writes
interface irpd_cfg_if import irpd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WIDTH_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/ir_pulse_distance_decoder.sv */
// Infrared pulse distance decoder, top level
// Depends on irpd_pkg, irpd_if.sv and ir_pulse_distance_decoder_macros.svh
//
// Usage:
//   pulse_i  : one item per captured mark or space width (us), frame_end set on
//              the last pulse of a frame
//   result_o : one item per frame: 64-bit code (LSB first), bit count, status
//   cfg_i    : register writes (index, data), always ready; write only while idle
// Path: a pulse is held in the input register and decoded from there; if it
//   ends a frame its result is written to the result register that drives result_o.
// Throughput: one pulse per cycle while no frame end stalls; the single decode
//   stage updates frame state by window compares, at most one bit per item.
// Stall: when a result waits on result_o, pulses that do not end a frame still
//   pass; a second frame end holds in the input register and pulse_i drops
//   ready until the waiting result is taken.
// Reset: configuration returns to its default windows, the code register
//   clears and the decoder waits for a header mark. The code register keeps
//   its value between frames; phase, bit count and stop reason restart.
`timescale 1ns / 1ps
`include "ir_pulse_distance_decoder_macros.svh"

module ir_pulse_distance_decoder import irpd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  irpd_in_if.sink      pulse_i,
  irpd_out_if.source   result_o,
  irpd_cfg_if.sink     cfg_i
);

  cfg_t               cfg_q;

  logic               s1_valid_q;
  logic [WIDTH_W-1:0] s1_width_q;
  logic               s1_last_q;
  logic               s1_fire;
  logic               out_free;

  phase_e             phase_q, phase_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  status_e            stop_q, stop_d;
  status_e            status_d;
  logic [CNT_W-1:0]   cnt_res_d;

  logic               out_valid_q;
  logic [CODE_W-1:0]  out_code_q;
  logic [CNT_W-1:0]   out_cnt_q;
  status_e            out_status_q;

  logic               end_fire;
  logic               hdr_phase;
  logic               idle_start;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_HDR_MARK:   cfg_q.hdr_mark   <= cfg_i.data;
        CFG_HDR_SPACE:  cfg_q.hdr_space  <= cfg_i.data;
        CFG_BIT_MARK:   cfg_q.bit_mark   <= cfg_i.data;
        CFG_ZERO_SPACE: cfg_q.zero_space <= cfg_i.data;
        CFG_ONE_SPACE:  cfg_q.one_space  <= cfg_i.data;
        CFG_MARK_TOL:   cfg_q.mark_tol   <= cfg_i.data;
        CFG_SPACE_TOL:  cfg_q.space_tol  <= cfg_i.data;
        default:        cfg_q <= cfg_q;
      endcase
    end
  end

  // handshake: a frame end needs a free output slot
  assign out_free      = !out_valid_q || result_o.ready;
  assign s1_fire       = s1_valid_q && (!s1_last_q || out_free);
  assign pulse_i.ready = !s1_valid_q || s1_fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pulse_i.ready) begin
      s1_valid_q <= pulse_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pulse_i.ready && pulse_i.valid) begin
      s1_width_q <= pulse_i.pulse_width;
      s1_last_q  <= pulse_i.frame_end;
    end
  end

  // decode state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR_MARK;
      code_q  <= '0;
      cnt_q   <= '0;
      stop_q  <= ST_COMPLETE;
    end else begin
      phase_q <= phase_d;
      code_q  <= code_d;
      cnt_q   <= cnt_d;
      stop_q  <= stop_d;
    end
  end

  // next state and frame result
  always_comb begin
    logic             win_zero;
    logic             win_one;
    logic [CNT_W-1:0] cnt_inc;
    win_zero  = in_window(s1_width_q, cfg_q.zero_space, cfg_q.space_tol);
    win_one   = in_window(s1_width_q, cfg_q.one_space, cfg_q.space_tol);
    cnt_inc   = cnt_q + CNT_W'(1);
    phase_d   = phase_q;
    code_d    = code_q;
    cnt_d     = cnt_q;
    stop_d    = stop_q;
    status_d  = ST_EARLY;
    cnt_res_d = cnt_q;

    if (s1_fire) begin
      unique case (phase_q)
        PH_HDR_MARK: begin
          if (in_window(s1_width_q, cfg_q.hdr_mark, cfg_q.space_tol)) begin
            phase_d = PH_HDR_SPACE;
          end else begin
            phase_d = PH_HALTED;
            stop_d  = ST_HEADER;
          end
        end
        PH_HDR_SPACE: begin
          if (in_window(s1_width_q, cfg_q.hdr_space, cfg_q.space_tol)) begin
            phase_d = PH_BIT_MARK;
          end else begin
            phase_d = PH_HALTED;
            stop_d  = ST_HEADER;
          end
        end
        // marks outside the window are skipped
        PH_BIT_MARK: begin
          if (in_window(s1_width_q, cfg_q.bit_mark, cfg_q.mark_tol)) begin
            phase_d = PH_BIT_SPACE;
          end
        end
        PH_BIT_SPACE: begin
          if (win_zero || win_one) begin
            code_d[cnt_q[IDX_W-1:0]] = !win_zero;
            cnt_d = cnt_inc;
            if (cnt_inc >= CNT_W'(CODE_BITS)) begin
              phase_d = PH_HALTED;
              stop_d  = ST_COMPLETE;
            end else begin
              phase_d = PH_BIT_MARK;
            end
          end else begin
            phase_d = PH_HALTED;
            stop_d  = ST_BADSPACE;
          end
        end
        PH_HALTED: phase_d = PH_HALTED;
        default:   phase_d = PH_HDR_MARK;
      endcase

      // status as the frame stands after this pulse
      priority if (phase_d == PH_HALTED) begin
        status_d = stop_d;
      end else if (phase_d == PH_HDR_MARK || phase_d == PH_HDR_SPACE) begin
        status_d = ST_HEADER;
      end else begin
        status_d = ST_EARLY;
      end
      cnt_res_d = cnt_d;

      // frame end restarts the decoder, the code is kept
      if (s1_last_q) begin
        phase_d = PH_HDR_MARK;
        cnt_d   = '0;
        stop_d  = ST_COMPLETE;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_code_q   <= code_d;
      out_cnt_q    <= cnt_res_d;
      out_status_q <= status_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.code_bits    = out_code_q;
  assign result_o.bits_decoded = out_cnt_q;
  assign result_o.frame_status = out_status_q;

  // terms used by the checks
  assign end_fire   = s1_fire && s1_last_q;
  assign hdr_phase  = (phase_q == PH_HDR_MARK) || (phase_q == PH_HDR_SPACE);
  assign idle_start = (phase_q == PH_HDR_MARK) && (cnt_q == '0);

  // checks
  `IRPD_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CNT_W'(CODE_BITS), "bit count beyond code size")
  `IRPD_ASSERT_NOW(a_hdr_no_bits, hdr_phase, cnt_q == '0, "bits counted before header")
  `IRPD_ASSERT_NEXT(a_end_restart, end_fire, idle_start, "decoder not restarted after frame end")
  `IRPD_ASSERT_NEXT(a_end_result, end_fire, out_valid_q, "frame end gave no result")

endmodule
